### rtl/core/gate_levelize_and_reorder_macros.svh
// assertion helpers shared by the core
`ifndef GATE_LEVELIZE_AND_REORDER_MACROS_SVH
`define GATE_LEVELIZE_AND_REORDER_MACROS_SVH

// same-cycle implication
`define GLR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GLR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/glr_pkg.sv
package glr_pkg;

	localparam int WIRE_W = 16;
	localparam int NUM_BUCKETS = 2 ** WIRE_W;

	localparam int DEF_MAX_WIRES = 65536;
	localparam int DEF_MAX_GATES = 65536;
	localparam int DEF_MAX_LEVELS = 4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	typedef struct packed {
		logic              command;
		logic [WIRE_W-1:0] first_input_wire;
		logic [WIRE_W-1:0] second_input_wire;
		logic [WIRE_W-1:0] output_wire;
		logic              gate_is_xor;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [1:0]        level;
		logic [15:0]       original_index;
		logic              fetched_is_xor;
		logic [WIRE_W-1:0] fetched_first_input;
		logic [WIRE_W-1:0] fetched_second_input;
		logic [WIRE_W-1:0] fetched_output;
		logic [15:0]       table_slot;
		logic              last_in_order;
	} rsp_t;

	// wire level memory access, one port
	typedef struct packed {
		logic              ren;
		logic [WIRE_W-1:0] raddr;
		logic              we;
		logic [WIRE_W-1:0] waddr;
	} wmem_ctl_t;

endpackage

### rtl/core/gate_levelize_and_reorder.sv
// Gate levelizer and reorderer. Commands are taken when start is high and busy is low; each
// produces exactly one result, shown on rsp for the single cycle that done is high, and the
// receiver cannot hold it off. A load steps through S_LA, S_LB and S_LC (one wire level memory
// port, read twice then written). A fetch steps through S_FO, S_FG and S_FE (order memory read,
// then gate memory read). The first fetch after loading builds the order first by a counting
// sort per level over the 65536-entry bucket memory: per level the buckets are cleared, the
// level's xor gates are counted per first input, the counts become start positions and the
// level's gates are placed. After reset and after the last gate is fetched, busy stays high
// while the wire level memory, min(MAX_WIRES, 65536) entries, is swept clear one entry a cycle.
module gate_levelize_and_reorder #(
	parameter int MAX_WIRES = glr_pkg::DEF_MAX_WIRES,
	parameter int MAX_GATES = glr_pkg::DEF_MAX_GATES,
	parameter int MAX_LEVELS = glr_pkg::DEF_MAX_LEVELS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  glr_pkg::req_t req,
	output logic          done,
	output glr_pkg::rsp_t rsp
);
	import glr_pkg::*;

	`include "gate_levelize_and_reorder_macros.svh"

	localparam int LW = $clog2(MAX_LEVELS);
	localparam int GIW = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
	localparam int CW = $clog2(MAX_GATES + 1);

	typedef struct packed {
		logic [WIRE_W-1:0] in0;
		logic [WIRE_W-1:0] in1;
		logic [WIRE_W-1:0] outw;
		logic              is_xor;
		logic [LW-1:0]     lvl;
	} gate_t;

	typedef enum logic [15:0] {
		S_IDLE = 16'h0001,
		S_LA   = 16'h0002,
		S_LB   = 16'h0004,
		S_LC   = 16'h0008,
		S_BCLR = 16'h0010,
		S_CA   = 16'h0020,
		S_CB   = 16'h0040,
		S_CC   = 16'h0080,
		S_PA   = 16'h0100,
		S_PB   = 16'h0200,
		S_LPA  = 16'h0400,
		S_LPB  = 16'h0800,
		S_LPC  = 16'h1000,
		S_FO   = 16'h2000,
		S_FG   = 16'h4000,
		S_FE   = 16'h8000
	} state_t;

	state_t            st_q;
	req_t              req_q;
	rsp_t              rsp_q;
	logic              done_q;
	logic [CW-1:0]     gl_q, fpos_q, slot_q, base_q, nx_q, run_q, g_q;
	logic              drain_q;
	logic [LW-1:0]     lv_q, la_q;
	logic [WIRE_W-1:0] ptr_q;
	logic [CW-1:0]     tot_q [MAX_LEVELS];
	logic [CW-1:0]     nxt_q [MAX_LEVELS];

	// memories
	gate_t         gate_mem [MAX_GATES];
	logic [GIW-1:0] ord_mem [MAX_GATES];
	logic [CW-1:0] bkt_mem [NUM_BUCKETS];
	gate_t         gate_rd_q;
	logic [GIW-1:0] ord_rd_q;
	logic [CW-1:0] bkt_rd_q;

	logic              gate_we, gate_ren;
	logic [GIW-1:0]    gate_raddr;
	gate_t             gate_wdata;
	logic              ord_we, ord_ren;
	logic [GIW-1:0]    ord_waddr, ord_wdata;
	logic              bkt_we, bkt_ren;
	logic [WIRE_W-1:0] bkt_waddr, bkt_raddr;
	logic [CW-1:0]     bkt_wdata;

	wmem_ctl_t     wctl;
	logic [LW-1:0] wrd, lmax, lnew;
	logic [LW:0]   lsum;
	logic          ovf, wclr_start, wclr_busy;
	logic          full, g_last, lv_match, fetch_last;
	logic          accept, refuse, empty_fetch;

	glr_wire_mem #(
		.MAX_WIRES(MAX_WIRES),
		.LW(LW)
	) u_wire_mem (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(wctl),
		.wdata(lnew),
		.rdata(wrd),
		.clr_start(wclr_start),
		.clr_busy(wclr_busy)
	);

	// level of the gate being loaded
	assign lmax = (la_q > wrd) ? la_q : wrd;
	assign lsum = {1'b0, lmax} + 1'b1;
	assign ovf = (lsum > (LW + 1)'(MAX_LEVELS - 1));
	assign lnew = ovf ? LW'(MAX_LEVELS - 1) : lsum[LW-1:0];

	assign full = (gl_q == CW'(MAX_GATES));
	assign g_last = ((g_q + 1'b1) == gl_q);
	assign lv_match = (gate_rd_q.lvl == lv_q);
	assign fetch_last = ((fpos_q + 1'b1) == gl_q);

	// command acceptance and immediate refusal
	assign accept = start && !busy;
	assign refuse = (req.command == CMD_LOAD) ? (drain_q || full) : (gl_q == '0);
	assign empty_fetch = accept && (req.command == CMD_FETCH) && (gl_q == '0);

	assign busy = (st_q != S_IDLE) || wclr_busy;
	assign done = done_q;
	assign rsp = rsp_q;

	// memory port selection per state
	always_comb begin
		wctl = '0;
		gate_we = 1'b0;
		gate_ren = 1'b0;
		gate_raddr = g_q[GIW-1:0];
		gate_wdata = '{in0: req_q.first_input_wire, in1: req_q.second_input_wire,
			outw: req_q.output_wire, is_xor: req_q.gate_is_xor, lvl: lnew};
		ord_we = 1'b0;
		ord_ren = 1'b0;
		ord_waddr = nx_q[GIW-1:0];
		ord_wdata = g_q[GIW-1:0];
		bkt_we = 1'b0;
		bkt_ren = 1'b0;
		bkt_waddr = ptr_q;
		bkt_raddr = ptr_q;
		bkt_wdata = '0;
		wclr_start = 1'b0;
		case (st_q)
			S_LA: begin
				wctl.ren = 1'b1;
				wctl.raddr = req_q.first_input_wire;
			end
			S_LB: begin
				wctl.ren = 1'b1;
				wctl.raddr = req_q.second_input_wire;
			end
			S_LC: begin
				wctl.we = 1'b1;
				wctl.waddr = req_q.output_wire;
				gate_we = 1'b1;
			end
			S_BCLR: begin
				bkt_we = 1'b1;
			end
			S_CA, S_LPA: begin
				gate_ren = 1'b1;
			end
			S_CB: begin
				bkt_ren = lv_match && gate_rd_q.is_xor;
				bkt_raddr = gate_rd_q.in0;
			end
			S_CC: begin
				bkt_we = 1'b1;
				bkt_waddr = gate_rd_q.in0;
				bkt_wdata = bkt_rd_q + 1'b1;
			end
			S_PA: begin
				bkt_ren = 1'b1;
			end
			S_PB: begin
				bkt_we = 1'b1;
				bkt_wdata = run_q;
			end
			S_LPB: begin
				ord_we = lv_match && !gate_rd_q.is_xor;
				bkt_ren = lv_match && gate_rd_q.is_xor;
				bkt_raddr = gate_rd_q.in0;
			end
			S_LPC: begin
				ord_we = 1'b1;
				ord_waddr = bkt_rd_q[GIW-1:0];
				bkt_we = 1'b1;
				bkt_waddr = gate_rd_q.in0;
				bkt_wdata = bkt_rd_q + 1'b1;
			end
			S_FO: begin
				ord_ren = 1'b1;
			end
			S_FG: begin
				gate_ren = 1'b1;
				gate_raddr = ord_rd_q;
			end
			S_FE: begin
				wclr_start = fetch_last;
			end
			default: begin
			end
		endcase
	end

	// gate, order and bucket storage
	always_ff @(posedge clk) begin
		if (gate_we) begin
			gate_mem[gl_q[GIW-1:0]] <= gate_wdata;
		end
		if (gate_ren) begin
			gate_rd_q <= gate_mem[gate_raddr];
		end
		if (ord_we) begin
			ord_mem[ord_waddr] <= ord_wdata;
		end
		if (ord_ren) begin
			ord_rd_q <= ord_mem[fpos_q[GIW-1:0]];
		end
		if (bkt_we) begin
			bkt_mem[bkt_waddr] <= bkt_wdata;
		end
		if (bkt_ren) begin
			bkt_rd_q <= bkt_mem[bkt_raddr];
		end
	end

	// result strobe: refused commands answer at once, others at the end of their sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((st_q == S_IDLE) && accept && refuse) || (st_q == S_LC) ||
				(st_q == S_FE);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			gl_q <= '0;
			fpos_q <= '0;
			slot_q <= '0;
			drain_q <= 1'b0;
			lv_q <= '0;
			base_q <= '0;
			nx_q <= '0;
			run_q <= '0;
			g_q <= '0;
			ptr_q <= '0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				tot_q[i] <= '0;
				nxt_q[i] <= '0;
			end
		end else begin
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						req_q <= req;
						if (req.command == CMD_LOAD) begin
							if (drain_q || full) begin
								rsp_q <= '{status: ST_REFUSED, default: '0};
							end else begin
								st_q <= S_LA;
							end
						end else if (gl_q == '0) begin
							rsp_q <= '{status: ST_REFUSED, default: '0};
						end else if (!drain_q) begin
							lv_q <= '0;
							base_q <= '0;
							ptr_q <= '0;
							st_q <= S_BCLR;
						end else begin
							st_q <= S_FO;
						end
					end
				end
				S_LA: st_q <= S_LB;
				S_LB: begin
					la_q <= wrd;
					st_q <= S_LC;
				end
				S_LC: begin
					tot_q[lnew] <= tot_q[lnew] + 1'b1;
					if (!req_q.gate_is_xor) begin
						nxt_q[lnew] <= nxt_q[lnew] + 1'b1;
					end
					gl_q <= gl_q + 1'b1;
					rsp_q <= '{status: ovf ? ST_OVF : ST_OK, level: 2'(lnew),
						original_index: 16'(gl_q), default: '0};
					st_q <= S_IDLE;
				end
				// zero the buckets, then set up this level's running positions
				S_BCLR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == '1) begin
						g_q <= '0;
						nx_q <= base_q;
						run_q <= base_q + nxt_q[lv_q];
						st_q <= S_CA;
					end
				end
				// count xor gates of this level per first input
				S_CA: st_q <= S_CB;
				S_CB, S_CC: begin
					if (st_q == S_CB && lv_match && gate_rd_q.is_xor) begin
						st_q <= S_CC;
					end else begin
						g_q <= g_q + 1'b1;
						st_q <= g_last ? S_PA : S_CA;
					end
				end
				// bucket counts become start positions
				S_PA: st_q <= S_PB;
				S_PB: begin
					run_q <= run_q + bkt_rd_q;
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == '1) begin
						g_q <= '0;
						st_q <= S_LPA;
					end else begin
						st_q <= S_PA;
					end
				end
				// place gates of this level
				S_LPA: st_q <= S_LPB;
				S_LPB, S_LPC: begin
					if (st_q == S_LPB && lv_match && gate_rd_q.is_xor) begin
						st_q <= S_LPC;
					end else begin
						if (st_q == S_LPB && lv_match) begin
							nx_q <= nx_q + 1'b1;
						end
						g_q <= g_q + 1'b1;
						if (g_last) begin
							base_q <= base_q + tot_q[lv_q];
							ptr_q <= '0;
							if (lv_q == LW'(MAX_LEVELS - 1)) begin
								drain_q <= 1'b1;
								fpos_q <= '0;
								slot_q <= '0;
								st_q <= S_FO;
							end else begin
								lv_q <= lv_q + 1'b1;
								st_q <= S_BCLR;
							end
						end else begin
							st_q <= S_LPA;
						end
					end
				end
				// hand out the next gate in the new order
				S_FO: st_q <= S_FG;
				S_FG: st_q <= S_FE;
				S_FE: begin
					rsp_q.status <= ST_OK;
					rsp_q.level <= 2'(gate_rd_q.lvl);
					rsp_q.original_index <= 16'(ord_rd_q);
					rsp_q.fetched_is_xor <= gate_rd_q.is_xor;
					rsp_q.fetched_first_input <= gate_rd_q.in0;
					rsp_q.fetched_second_input <= gate_rd_q.in1;
					rsp_q.fetched_output <= gate_rd_q.outw;
					rsp_q.table_slot <= gate_rd_q.is_xor ? 16'd0 : 16'(slot_q);
					rsp_q.last_in_order <= fetch_last;
					if (fetch_last) begin
						gl_q <= '0;
						fpos_q <= '0;
						slot_q <= '0;
						drain_q <= 1'b0;
						for (int i = 0; i < MAX_LEVELS; i++) begin
							tot_q[i] <= '0;
							nxt_q[i] <= '0;
						end
					end else begin
						fpos_q <= fpos_q + 1'b1;
						if (!gate_rd_q.is_xor) begin
							slot_q <= slot_q + 1'b1;
						end
					end
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// checks
	`GLR_ASSERT_NEXT(a_empty_fetch, empty_fetch, done && rsp.status == ST_REFUSED, "fetch not refused")
	`GLR_ASSERT_SAME(a_clear_busy, wclr_busy, busy, "wire clear running while not busy")
	`GLR_ASSERT_SAME(a_drain_nonempty, drain_q, gl_q != '0, "draining with no gates")
	`GLR_ASSERT_NEXT(a_last_clears, done && rsp.last_in_order, gl_q == '0 && !drain_q, "not cleared")

endmodule

### rtl/core/glr_wire_mem.sv
module glr_wire_mem #(
	parameter int MAX_WIRES = glr_pkg::DEF_MAX_WIRES,
	parameter int LW = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  glr_pkg::wmem_ctl_t ctl,
	input  logic [LW-1:0]     wdata,
	output logic [LW-1:0]     rdata,
	input  logic              clr_start,
	output logic              clr_busy
);
	import glr_pkg::*;

	localparam int WDEPTH = (MAX_WIRES < NUM_BUCKETS) ? MAX_WIRES : NUM_BUCKETS;
	localparam int WAW = $clog2(WDEPTH);

	logic [LW-1:0]  mem [WDEPTH];
	logic [LW-1:0]  rd_q;
	logic [WAW-1:0] cnt_q;
	logic           clr_q;
	logic           r_in, w_in;

	// indices past the table read as level 0, writes there are dropped
	assign r_in = (32'(ctl.raddr) < WDEPTH);
	assign w_in = (32'(ctl.waddr) < WDEPTH);

	// clearing sweep, one entry a cycle, after reset and on request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			cnt_q <= '0;
		end else if (clr_q) begin
			if (cnt_q == WAW'(WDEPTH - 1)) begin
				clr_q <= 1'b0;
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else if (clr_start) begin
			clr_q <= 1'b1;
			cnt_q <= '0;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[cnt_q] <= '0;
		end else if (ctl.we && w_in) begin
			mem[ctl.waddr[WAW-1:0]] <= wdata;
		end
		if (ctl.ren) begin
			rd_q <= r_in ? mem[ctl.raddr[WAW-1:0]] : '0;
		end
	end

	assign rdata = rd_q;
	assign clr_busy = clr_q;

endmodule

### tb/gate_levelize_and_reorder_test.sv
module gate_levelize_and_reorder_test;
	import glr_pkg::*;

	localparam int NUM_WIRES = 65536;
	localparam int NUM_GATES = 65536;
	localparam int TOP_LEVEL = 3;

	typedef struct {
		logic [15:0] in0;
		logic [15:0] in1;
		logic [15:0] outw;
		logic        is_xor;
		logic [1:0]  lvl;
	} gate_rec_t;

	// one row of the directed stimulus
	typedef struct {
		req_t cmd;
		bit   typed;
		rsp_t want;
	} stim_row_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  done;
	rsp_t  rsp;

	// model of the block state
	logic [1:0]  wire_lvl [NUM_WIRES];
	gate_rec_t   gates [$];
	int unsigned sorted_order [$];
	bit          in_drain;
	int unsigned drain_pos;
	int unsigned slot_count;

	stim_row_t   stim_rows [$];
	rsp_t        pending_rsp [$];
	int unsigned fail_count;
	int unsigned load_count;
	int unsigned fetch_count;
	int unsigned refused_count;
	int unsigned ovf_count;
	int unsigned burst_left;

	gate_levelize_and_reorder i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#60000000;
		$display("FAILED: results differ");
		$finish;
	end

	// levelized order: non-xor in load order, then xor by first input, stable
	function automatic void build_level_order();
		int unsigned xq [$];
		int unsigned k;
		int unsigned t;
		int j;
		sorted_order.delete();
		for (int lv = 0; lv <= TOP_LEVEL; lv++) begin
			xq.delete();
			for (int g = 0; g < gates.size(); g++) begin
				if (gates[g].lvl == lv && !gates[g].is_xor)
					sorted_order.insert(sorted_order.size(), g);
				else if (gates[g].lvl == lv)
					xq.insert(xq.size(), g);
			end
			for (k = 1; k < xq.size(); k++) begin
				t = xq[k];
				j = k - 1;
				while (j >= 0 && gates[xq[j]].in0 > gates[t].in0) begin
					xq[j + 1] = xq[j];
					j--;
				end
				xq[j + 1] = t;
			end
			foreach (xq[i])
				sorted_order.insert(sorted_order.size(), xq[i]);
		end
	endfunction

	function automatic void clear_model();
		foreach (wire_lvl[i])
			wire_lvl[i] = 2'd0;
		gates.delete();
		sorted_order.delete();
		in_drain = 1'b0;
		drain_pos = 0;
		slot_count = 0;
	endfunction

	function automatic rsp_t levelize_step(req_t r);
		rsp_t res;
		gate_rec_t g;
		int unsigned lv;
		int unsigned id;
		res = '0;
		if (r.command == CMD_LOAD) begin
			load_count++;
			if (in_drain || gates.size() >= NUM_GATES) begin
				res.status = ST_REFUSED;
				refused_count++;
				return res;
			end
			lv = 32'((wire_lvl[r.first_input_wire] > wire_lvl[r.second_input_wire]) ?
				wire_lvl[r.first_input_wire] : wire_lvl[r.second_input_wire]);
			lv++;
			res.status = ST_OK;
			if (lv > TOP_LEVEL) begin
				lv = TOP_LEVEL;
				res.status = ST_OVF;
				ovf_count++;
			end
			wire_lvl[r.output_wire] = lv[1:0];
			g.in0 = r.first_input_wire;
			g.in1 = r.second_input_wire;
			g.outw = r.output_wire;
			g.is_xor = r.gate_is_xor;
			g.lvl = lv[1:0];
			res.level = lv[1:0];
			res.original_index = 16'(gates.size());
			gates.insert(gates.size(), g);
			return res;
		end
		fetch_count++;
		if (gates.size() == 0) begin
			res.status = ST_REFUSED;
			refused_count++;
			return res;
		end
		if (!in_drain) begin
			build_level_order();
			in_drain = 1'b1;
			drain_pos = 0;
			slot_count = 0;
		end
		id = sorted_order[drain_pos];
		g = gates[id];
		res.status = ST_OK;
		res.level = g.lvl;
		res.original_index = 16'(id);
		res.fetched_is_xor = g.is_xor;
		res.fetched_first_input = g.in0;
		res.fetched_second_input = g.in1;
		res.fetched_output = g.outw;
		if (!g.is_xor) begin
			res.table_slot = 16'(slot_count);
			slot_count++;
		end
		res.last_in_order = (drain_pos + 1 == gates.size());
		drain_pos++;
		if (res.last_in_order)
			clear_model();
		return res;
	endfunction

	// issue one transaction, with bursts and random gaps on the sender side
	task automatic issue(req_t r, bit typed, rsp_t want);
		rsp_t got;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		got = levelize_step(r);
		pending_rsp.insert(pending_rsp.size(), typed ? want : got);
	endtask

	task automatic drain_wait();
		start <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	function automatic req_t make_req(logic c, int a, int b, int o, logic x);
		req_t r;
		r.command = c;
		r.first_input_wire = 16'(a);
		r.second_input_wire = 16'(b);
		r.output_wire = 16'(o);
		r.gate_is_xor = x;
		return r;
	endfunction

	function automatic rsp_t load_rsp(logic [1:0] st, logic [1:0] lv, int id);
		rsp_t res;
		res = '0;
		res.status = st;
		res.level = lv;
		res.original_index = 16'(id);
		return res;
	endfunction

	// append one directed row
	function automatic void add_row(req_t c, bit typed, rsp_t w);
		stim_row_t row;
		row.cmd = c;
		row.typed = typed;
		row.want = w;
		stim_rows.insert(stim_rows.size(), row);
	endfunction

	function automatic logic [15:0] pick_wire();
		if ($urandom_range(0, 19) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 47));
	endfunction

	// check each result against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("result with no transaction pending");
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$error("status exp %0d got %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.level !== want.level) begin
					$error("level exp %0d got %0d", want.level, rsp.level);
					fail_count++;
				end
				if (rsp.original_index !== want.original_index) begin
					$error("original_index exp %0d got %0d",
						want.original_index, rsp.original_index);
					fail_count++;
				end
				if (rsp.fetched_is_xor !== want.fetched_is_xor) begin
					$error("fetched_is_xor exp %0d got %0d",
						want.fetched_is_xor, rsp.fetched_is_xor);
					fail_count++;
				end
				if (rsp.fetched_first_input !== want.fetched_first_input) begin
					$error("fetched_first_input exp %0d got %0d",
						want.fetched_first_input, rsp.fetched_first_input);
					fail_count++;
				end
				if (rsp.fetched_second_input !== want.fetched_second_input) begin
					$error("fetched_second_input exp %0d got %0d",
						want.fetched_second_input, rsp.fetched_second_input);
					fail_count++;
				end
				if (rsp.fetched_output !== want.fetched_output) begin
					$error("fetched_output exp %0d got %0d",
						want.fetched_output, rsp.fetched_output);
					fail_count++;
				end
				if (rsp.table_slot !== want.table_slot) begin
					$error("table_slot exp %0d got %0d", want.table_slot, rsp.table_slot);
					fail_count++;
				end
				if (rsp.last_in_order !== want.last_in_order) begin
					$error("last_in_order exp %0d got %0d",
						want.last_in_order, rsp.last_in_order);
					fail_count++;
				end
			end
		end
	end

	initial begin
		rsp_t none;
		rsp_t refused;
		int unsigned n_load;
		int unsigned n_tail;
		logic xr;

		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		fail_count = 0;
		load_count = 0;
		fetch_count = 0;
		refused_count = 0;
		ovf_count = 0;
		burst_left = 0;
		clear_model();
		none = '0;
		refused = '0;
		refused.status = ST_REFUSED;

		// directed rows: chains up to overflow, wire extremes, xor ties
		add_row(make_req(CMD_FETCH, 0, 0, 0, 1'b0), 1'b1, refused);
		add_row(make_req(CMD_LOAD, 0, 0, 10, 1'b0), 1'b1, load_rsp(ST_OK, 2'd1, 0));
		add_row(make_req(CMD_LOAD, 10, 10, 11, 1'b1), 1'b1, load_rsp(ST_OK, 2'd2, 1));
		add_row(make_req(CMD_LOAD, 11, 0, 12, 1'b0), 1'b1, load_rsp(ST_OK, 2'd3, 2));
		add_row(make_req(CMD_LOAD, 12, 12, 13, 1'b1), 1'b1, load_rsp(ST_OVF, 2'd3, 3));
		add_row(make_req(CMD_LOAD, 65535, 65535, 65535, 1'b1), 1'b1,
			load_rsp(ST_OK, 2'd1, 4));
		add_row(make_req(CMD_LOAD, 5, 65535, 0, 1'b0), 1'b1, load_rsp(ST_OK, 2'd2, 5));
		add_row(make_req(CMD_LOAD, 3, 4, 20, 1'b1), 1'b1, load_rsp(ST_OK, 2'd1, 6));
		add_row(make_req(CMD_LOAD, 3, 9, 21, 1'b1), 1'b1, load_rsp(ST_OK, 2'd1, 7));
		add_row(make_req(CMD_LOAD, 13, 21, 22, 1'b0), 1'b1, load_rsp(ST_OVF, 2'd3, 8));
		add_row(make_req(CMD_LOAD, 1, 2, 23, 1'b0), 1'b1, load_rsp(ST_OK, 2'd1, 9));
		for (int i = 0; i < 5; i++)
			add_row(make_req(CMD_FETCH, 0, 0, 0, 1'b0), 1'b0, none);
		add_row(make_req(CMD_LOAD, 1, 1, 1, 1'b1), 1'b1, refused);
		for (int i = 0; i < 5; i++)
			add_row(make_req(CMD_FETCH, 0, 0, 0, 1'b0), 1'b0, none);
		add_row(make_req(CMD_FETCH, 0, 0, 0, 1'b0), 1'b1, refused);
		add_row(make_req(CMD_LOAD, 0, 0, 0, 1'b1), 1'b1, load_rsp(ST_OK, 2'd1, 0));
		add_row(make_req(CMD_FETCH, 0, 0, 0, 1'b0), 1'b0, none);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i])
			issue(stim_rows[i].cmd, stim_rows[i].typed, stim_rows[i].want);

		// random rounds: load a deep circuit, then drain it with refused loads mixed in
		for (int round = 0; round < 2; round++) begin
			n_load = $urandom_range(350, 400);
			for (int i = 0; i < n_load; i++) begin
				xr = 1'($urandom_range(0, 1));
				issue(make_req(CMD_LOAD, pick_wire(), pick_wire(), pick_wire(), xr), 1'b0, none);
			end
			if (round == 0)
				drain_wait();
			while (in_drain || gates.size() != 0) begin
				if ($urandom_range(0, 19) == 0)
					issue(make_req(CMD_LOAD, $urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535), 1'($urandom_range(0, 1))), 1'b0, none);
				else
					issue(make_req(CMD_FETCH, $urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535), 1'($urandom_range(0, 1))), 1'b0, none);
			end
			n_tail = $urandom_range(1, 3);
			for (int i = 0; i < n_tail; i++)
				issue(make_req(CMD_FETCH, 0, 0, 0, 1'b0), 1'b0, none);
		end

		drain_wait();
		repeat (20) @(posedge clk);
		$display("ran %0d loads and %0d fetches: %0d refused, %0d level overflows",
			load_count, fetch_count, refused_count, ovf_count);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
